### sv/bpq_pkg.sv
`default_nettype none
package bpq_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned RawW  = 32;
  localparam int unsigned ReqW  = 3;

  // Request codes.
  localparam logic [ReqW-1:0] ReqSample  = 3'd0;
  localparam logic [ReqW-1:0] ReqLock    = 3'd1;
  localparam logic [ReqW-1:0] ReqClear   = 3'd2;
  localparam logic [ReqW-1:0] ReqEnable  = 3'd3;
  localparam logic [ReqW-1:0] ReqDisable = 3'd4;

  // Register indexes on the configuration port.
  localparam int unsigned     RegAddrW      = 4;
  localparam logic [1:0]      RegTouchMode  = 2'd0;
  localparam logic [1:0]      RegTouchAbove = 2'd1;
  localparam logic [1:0]      RegThreshold  = 2'd2;
  localparam logic [1:0]      RegPressMs    = 2'd3;

  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [TimeW-1:0] now_ms;
    logic             pin_level;
    logic [RawW-1:0]  touch_raw;
    logic [TimeW-1:0] lock_ms;
  } in_word_t;

  typedef struct packed {
    logic is_held;
    logic is_touched;
    logic is_pressed;
    logic is_released;
    logic is_locked;
  } out_word_t;

  typedef struct packed {
    logic             touch_mode;
    logic             touch_above;
    logic [RawW-1:0]  touch_threshold;
    logic [TimeW-1:0] press_ms;
  } cfg_t;

endpackage
`default_nettype wire

### sv/bpq_cfg.sv
`default_nettype none
module bpq_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bpq_pkg::RegAddrW-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  output bpq_pkg::cfg_t                      cfg_o
);

  bpq_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        bpq_pkg::RegTouchMode:  cfg_d.touch_mode      = pwdata[0];
        bpq_pkg::RegTouchAbove: cfg_d.touch_above     = pwdata[0];
        bpq_pkg::RegThreshold:  cfg_d.touch_threshold = pwdata;
        bpq_pkg::RegPressMs:    cfg_d.press_ms        = pwdata;
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bpq_pkg::RegTouchMode:  prdata = {31'd0, cfg_q.touch_mode};
      bpq_pkg::RegTouchAbove: prdata = {31'd0, cfg_q.touch_above};
      bpq_pkg::RegThreshold:  prdata = cfg_q.touch_threshold;
      bpq_pkg::RegPressMs:    prdata = cfg_q.press_ms;
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

### sv/bpq_core.sv
`default_nettype none
module bpq_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bpq_pkg::cfg_t     cfg_i,
  input  wire bpq_pkg::in_word_t req_i,
  input  wire logic              step_i,
  output bpq_pkg::out_word_t     result_o
);

  logic                     enabled_q, enabled_d;
  logic                     locked_q, locked_d;
  logic                     held_q, held_d;
  logic                     touched_q, touched_d;
  logic                     pressed_q, pressed_d;
  logic                     released_q, released_d;
  logic [bpq_pkg::TimeW-1:0] lock_start_q, lock_start_d;
  logic [bpq_pkg::TimeW-1:0] lock_len_q, lock_len_d;
  logic [bpq_pkg::TimeW-1:0] hold_start_q, hold_start_d;

  logic [bpq_pkg::TimeW-1:0] lock_elapsed;
  logic [bpq_pkg::TimeW-1:0] hold_elapsed;
  logic                      still_locked;
  logic                      held_now;

  assign lock_elapsed = req_i.now_ms - lock_start_q;
  assign hold_elapsed = req_i.now_ms - hold_start_q;
  assign still_locked = locked_q && (lock_elapsed < lock_len_q);

  always_comb begin
    if (cfg_i.touch_mode) begin
      held_now = cfg_i.touch_above ? (req_i.touch_raw > cfg_i.touch_threshold)
                                   : (req_i.touch_raw < cfg_i.touch_threshold);
    end else begin
      held_now = !req_i.pin_level;
    end
  end

  always_comb begin
    enabled_d    = enabled_q;
    locked_d     = locked_q;
    held_d       = held_q;
    touched_d    = touched_q;
    pressed_d    = pressed_q;
    released_d   = released_q;
    lock_start_d = lock_start_q;
    lock_len_d   = lock_len_q;
    hold_start_d = hold_start_q;
    unique case (req_i.req_type)
      bpq_pkg::ReqSample: begin
        if (enabled_q && !still_locked) begin
          locked_d = 1'b0;
          held_d   = held_now;
          if (!held_now) begin
            if (touched_q) begin
              touched_d  = 1'b0;
              released_d = 1'b1;
            end
          end else if (touched_q) begin
            if (!pressed_q && (hold_elapsed > cfg_i.press_ms)) begin
              touched_d = 1'b0;
              pressed_d = 1'b1;
            end
          end else begin
            touched_d    = 1'b1;
            released_d   = 1'b0;
            hold_start_d = req_i.now_ms;
          end
        end
      end
      bpq_pkg::ReqLock: begin
        locked_d     = 1'b1;
        held_d       = 1'b0;
        touched_d    = 1'b0;
        pressed_d    = 1'b0;
        released_d   = 1'b0;
        lock_len_d   = req_i.lock_ms;
        lock_start_d = req_i.now_ms;
      end
      bpq_pkg::ReqClear: begin
        held_d     = 1'b0;
        pressed_d  = 1'b0;
        released_d = 1'b0;
      end
      bpq_pkg::ReqEnable: begin
        enabled_d = 1'b1;
      end
      bpq_pkg::ReqDisable: begin
        enabled_d  = 1'b0;
        held_d     = 1'b0;
        pressed_d  = 1'b0;
        released_d = 1'b0;
      end
      default: begin
        enabled_d = enabled_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q    <= 1'b1;
      locked_q     <= 1'b0;
      held_q       <= 1'b0;
      touched_q    <= 1'b0;
      pressed_q    <= 1'b0;
      released_q   <= 1'b0;
      lock_start_q <= '0;
      lock_len_q   <= '0;
      hold_start_q <= '0;
    end else if (step_i) begin
      enabled_q    <= enabled_d;
      locked_q     <= locked_d;
      held_q       <= held_d;
      touched_q    <= touched_d;
      pressed_q    <= pressed_d;
      released_q   <= released_d;
      lock_start_q <= lock_start_d;
      lock_len_q   <= lock_len_d;
      hold_start_q <= hold_start_d;
    end
  end

  assign result_o.is_held     = held_d;
  assign result_o.is_touched  = touched_d;
  assign result_o.is_pressed  = pressed_d;
  assign result_o.is_released = released_d;
  assign result_o.is_locked   = locked_d;

endmodule
`default_nettype wire

### sv/button_press_qualifier.sv
// Path: an accepted word waits in the input register; its result word is written
// into the result register as the word moves on, and is offered from there.
// Throughput: one word per cycle while results are taken; the only feedback is the
// single state update, made as a word moves from the input to the result register.
// Reset: rst_ni is asynchronous and active low; it empties both registers, sets
// enabled, clears every flag and time, and zeroes all configuration registers.
`default_nettype none
module button_press_qualifier (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire bpq_pkg::in_word_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output bpq_pkg::out_word_t                 out_data_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bpq_pkg::RegAddrW-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);

  // The input register holds one request word. It moves on whenever the
  // result register is empty or being drained, and at that same edge the
  // qualifier state takes its new value, so requests update state strictly
  // in arrival order.
  logic               s1_valid_q;
  bpq_pkg::in_word_t  s1_data_q;
  logic               out_valid_q;
  bpq_pkg::out_word_t out_data_q;
  logic               advance;
  bpq_pkg::cfg_t      cfg;
  bpq_pkg::out_word_t result;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  bpq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Decision logic and state; the result is the flag set after the request.
  bpq_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .req_i    (s1_data_q),
    .step_i   (advance),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // A lockout clears every flag, and samples stay ignored until it ends.
  a_locked_clears_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.is_locked |->
      !out_data_q.is_held && !out_data_q.is_touched &&
      !out_data_q.is_pressed && !out_data_q.is_released)
    else $error("locked result with a flag set");

  // A held input is either in its touch phase or has already been qualified.
  a_held_implies_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.is_held |-> out_data_q.is_touched || out_data_q.is_pressed)
    else $error("held without touch phase or press");

  // The input side stalls only when a word is parked behind a blocked result.
  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a blocked result");

  // A word that moves on always lands in the result register.
  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced word lost");
`endif

endmodule
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the button press qualifier.
//
// Input words come from a queue that the stimulus process fills. A clocked
// driver offers them on the valid/ready input channel. A clocked monitor takes
// result words off the output channel. Each accepted input word is run
// through a local copy of the qualifier state as it is accepted. The flags
// that copy predicts are queued and compared, field by field, with the result
// words in order.
//
// The run is split into phases. Each phase writes all four registers over the
// APB port while the block is drained, and then applies one of four mixes of
// sender idling and receiver stalls. The first phase starts with a short directed
// sequence that walks the corner cases. Every phase then adds random traffic
// built mostly from realistic press, release and lockout sequences, with some
// loose words mixed in.
module tb;

  localparam int unsigned HalfPeriod   = 4;
  localparam int unsigned ResetCycles  = 12;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned PhaseWords   = 128;
  localparam int unsigned DrainCycles  = 3;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned MaxReports   = 50;

  // All inputs of the block hold known values from time zero.
  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  bpq_pkg::in_word_t in_word = '0;
  logic        out_ready = 1'b0;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [bpq_pkg::RegAddrW-1:0] paddr = '0;
  logic [31:0] pwdata    = '0;

  logic        in_ready;
  logic        out_valid;
  bpq_pkg::out_word_t out_word;
  logic [31:0] prdata;
  logic        pready;

  button_press_qualifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // Words waiting to be driven, and the flags each accepted word should yield.
  bpq_pkg::in_word_t  pending_words[$];
  bpq_pkg::out_word_t expected_flags[$];

  // Register values as last written over APB.
  bpq_pkg::cfg_t cfg_shadow = '0;

  // Local copy of the qualifier state, at its reset values.
  logic        q_enabled    = 1'b1;
  logic        q_locked     = 1'b0;
  logic [31:0] q_lock_start = '0;
  logic [31:0] q_lock_len   = '0;
  logic        q_held       = 1'b0;
  logic        q_touched    = 1'b0;
  logic        q_pressed    = 1'b0;
  logic        q_released   = 1'b0;
  logic [31:0] q_hold_start = '0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles   = 0;
  int unsigned phase_items    = 0;

  // The millisecond clock seen by the stimulus. It only moves forward within a
  // phase, and it wraps through zero in some phases.
  logic [31:0] clock_ms = '0;

  // Applies one word to the local state and returns the flags it leaves.
  function automatic bpq_pkg::out_word_t qualify_word(bpq_pkg::in_word_t w);
    bpq_pkg::out_word_t f;
    logic               skip;
    skip = 1'b0;
    case (w.req_type)
      bpq_pkg::ReqSample: begin
        if (!q_enabled) begin
          skip = 1'b1;
        end else if (q_locked) begin
          // The lockout runs on wrapping time, like every elapsed time here.
          if (w.now_ms - q_lock_start < q_lock_len) skip = 1'b1;
          else q_locked = 1'b0;
        end
        if (!skip) begin
          if (cfg_shadow.touch_mode) begin
            q_held = cfg_shadow.touch_above ? (w.touch_raw > cfg_shadow.touch_threshold)
                                            : (w.touch_raw < cfg_shadow.touch_threshold);
          end else begin
            q_held = (w.pin_level == 1'b0);
          end
          if (!q_held) begin
            // Letting go ends a touch phase and reports the release.
            if (q_touched) begin
              q_touched  = 1'b0;
              q_released = 1'b1;
            end
          end else if (q_touched) begin
            // The press time is checked only until pressed is set.
            if (!q_pressed && (w.now_ms - q_hold_start > cfg_shadow.press_ms)) begin
              q_touched = 1'b0;
              q_pressed = 1'b1;
            end
          end else begin
            q_touched    = 1'b1;
            q_released   = 1'b0;
            q_hold_start = w.now_ms;
          end
        end
      end
      bpq_pkg::ReqLock: begin
        q_locked     = 1'b1;
        q_held       = 1'b0;
        q_touched    = 1'b0;
        q_pressed    = 1'b0;
        q_released   = 1'b0;
        q_lock_len   = w.lock_ms;
        q_lock_start = w.now_ms;
      end
      bpq_pkg::ReqClear: begin
        // Touched survives a clear.
        q_held     = 1'b0;
        q_pressed  = 1'b0;
        q_released = 1'b0;
      end
      bpq_pkg::ReqEnable: begin
        q_enabled = 1'b1;
      end
      bpq_pkg::ReqDisable: begin
        q_enabled  = 1'b0;
        q_held     = 1'b0;
        q_pressed  = 1'b0;
        q_released = 1'b0;
      end
      default: begin
        // Unknown request codes leave the state alone.
      end
    endcase
    f.is_held     = q_held;
    f.is_touched  = q_touched;
    f.is_pressed  = q_pressed;
    f.is_released = q_released;
    f.is_locked   = q_locked;
    return f;
  endfunction

  // Driver. Whenever the previous word was taken or none was offered, it offers
  // a new word or idles at random. Valid is assigned once per edge, so a word that
  // follows directly keeps valid high.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) expected_flags.push_back(qualify_word(in_word));
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_word  <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_flag(string name, logic want, logic got);
    if (want !== got) begin
      if (mismatch_count < MaxReports) begin
        $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
      end
      mismatch_count++;
    end
  endtask

  // Monitor. It takes result words in order, checks them against the oldest
  // prediction, and draws the receiver's ready for the next edge.
  bpq_pkg::out_word_t want_flags;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (expected_flags.size() == 0) begin
          if (mismatch_count < MaxReports) begin
            $display("%0t: result word with none expected, expected none, actual %b",
                     $time, out_word);
          end
          mismatch_count++;
        end else begin
          want_flags = expected_flags.pop_front();
          check_flag("is_held",     want_flags.is_held,     out_word.is_held);
          check_flag("is_touched",  want_flags.is_touched,  out_word.is_touched);
          check_flag("is_pressed",  want_flags.is_pressed,  out_word.is_pressed);
          check_flag("is_released", want_flags.is_released, out_word.is_released);
          check_flag("is_locked",   want_flags.is_locked,   out_word.is_locked);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog. It counts edges with work outstanding but no word moving on
  // either channel.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (pending_words.size() != 0 || in_valid || expected_flags.size() != 0) begin
      stall_cycles <= stall_cycles + 1;
    end else begin
      stall_cycles <= 0;
    end
  end

  initial begin
    wait (stall_cycles >= StallLimit);
    $display("FAIL");
    $finish;
  end

  // One APB write: a setup cycle, then an access cycle. The register takes
  // the value at the edge that ends the access cycle.
  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      bpq_pkg::RegTouchMode:  cfg_shadow.touch_mode      = value[0];
      bpq_pkg::RegTouchAbove: cfg_shadow.touch_above     = value[0];
      bpq_pkg::RegThreshold:  cfg_shadow.touch_threshold = value;
      bpq_pkg::RegPressMs:    cfg_shadow.press_ms        = value;
      default: ;
    endcase
  endtask

  // Blocks until every word has been driven and every result has come back,
  // then lets the pipeline settle.
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_flags.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic queue_word(bpq_pkg::in_word_t w);
    pending_words.push_back(w);
    phase_items++;
  endtask

  function automatic bpq_pkg::in_word_t make_word(logic [bpq_pkg::ReqW-1:0] req,
                                                  logic [31:0] at_ms, logic level,
                                                  logic [31:0] raw,
                                                  logic [31:0] lock_len);
    bpq_pkg::in_word_t w;
    w.req_type  = req;
    w.now_ms    = at_ms;
    w.pin_level = level;
    w.touch_raw = raw;
    w.lock_ms   = lock_len;
    return w;
  endfunction

  // Picks a touch reading that gives the wanted held decision where the
  // threshold allows one. Now and then it lands on or next to the threshold.
  function automatic logic [31:0] pick_raw(logic want_held);
    logic [31:0] thr;
    thr = cfg_shadow.touch_threshold;
    if ($urandom_range(7) == 0) return thr + $urandom_range(2) - 1;
    if (cfg_shadow.touch_above) begin
      if (want_held && thr != '1) return $urandom_range(32'hFFFF_FFFF, thr + 1);
      if (!want_held) return $urandom_range(thr, 0);
    end else begin
      if (want_held && thr != '0) return $urandom_range(thr - 1, 0);
      if (!want_held) return $urandom_range(32'hFFFF_FFFF, thr);
    end
    return $urandom();
  endfunction

  // A sample word that reads as held or not in the current mode. The field
  // that the mode ignores carries random data.
  function automatic bpq_pkg::in_word_t sample_word(logic [31:0] at_ms, logic want_held);
    bpq_pkg::in_word_t w;
    w = make_word(bpq_pkg::ReqSample, at_ms, 1'($urandom_range(1)), $urandom(),
                  $urandom());
    if (cfg_shadow.touch_mode) w.touch_raw = pick_raw(want_held);
    else w.pin_level = ~want_held;
    return w;
  endfunction

  // A press: a few idle samples, a hold of random length whose time steps are
  // scaled to the press time, sometimes a clear, then a release.
  task automatic queue_press_sequence();
    int unsigned n_idle;
    int unsigned n_hold;
    int unsigned step_max;
    n_idle   = $urandom_range(2);
    n_hold   = $urandom_range(8, 1);
    step_max = (cfg_shadow.press_ms > 400) ? 400 : cfg_shadow.press_ms / 2 + 2;
    repeat (n_idle) begin
      clock_ms = clock_ms + $urandom_range(step_max);
      queue_word(sample_word(clock_ms, 1'b0));
    end
    repeat (n_hold) begin
      clock_ms = clock_ms + $urandom_range(step_max);
      queue_word(sample_word(clock_ms, 1'b1));
    end
    if ($urandom_range(3) == 0) begin
      queue_word(make_word(bpq_pkg::ReqClear, $urandom(), 1'($urandom_range(1)),
                           $urandom(), $urandom()));
    end
    clock_ms = clock_ms + $urandom_range(step_max);
    queue_word(sample_word(clock_ms, 1'b0));
  endtask

  // A short lockout, followed by mostly held samples that may fall inside it or past its end.
  task automatic queue_lock_sequence();
    logic [31:0] lock_len;
    lock_len = $urandom_range(40);
    queue_word(make_word(bpq_pkg::ReqLock, clock_ms, 1'($urandom_range(1)), $urandom(),
                         lock_len));
    repeat ($urandom_range(8, 3)) begin
      clock_ms = clock_ms + $urandom_range(15);
      queue_word(sample_word(clock_ms, 1'($urandom_range(3) != 0)));
    end
  endtask

  // A loose word with any request code, unknown codes included, and fields
  // that are often fully random.
  task automatic queue_noise_word();
    bpq_pkg::in_word_t w;
    int unsigned       pick;
    w    = make_word(bpq_pkg::ReqSample, clock_ms + $urandom_range(20),
                     1'($urandom_range(1)), $urandom(), $urandom_range(60));
    pick = $urandom_range(99);
    if (pick < 35)      w.req_type = bpq_pkg::ReqSample;
    else if (pick < 47) w.req_type = bpq_pkg::ReqLock;
    else if (pick < 59) w.req_type = bpq_pkg::ReqClear;
    else if (pick < 72) w.req_type = bpq_pkg::ReqEnable;
    else if (pick < 84) w.req_type = bpq_pkg::ReqDisable;
    else                w.req_type = 3'($urandom_range(7, bpq_pkg::ReqDisable + 1));
    if ($urandom_range(3) == 0) w.now_ms = $urandom();
    if ($urandom_range(7) == 0) w.lock_ms = $urandom();
    queue_word(w);
    // A long lockout is broken off by a zero-length one, so that later
    // samples are not all ignored.
    if (w.req_type == bpq_pkg::ReqLock && w.lock_ms > 60) begin
      queue_word(sample_word(clock_ms, 1'b1));
      queue_word(make_word(bpq_pkg::ReqLock, clock_ms, 1'b1, $urandom(), '0));
    end
    if (w.req_type == bpq_pkg::ReqDisable && $urandom_range(9) < 7) begin
      queue_word(make_word(bpq_pkg::ReqEnable, $urandom(), 1'($urandom_range(1)),
                           $urandom(), $urandom()));
    end
  endtask

  // Corner cases, run in digital mode with a press time of zero: press on the
  // first later millisecond, a hold that does not re-check once pressed, a
  // release during a touch phase, a clear that keeps touched, a lockout
  // across the time wrap and its exact end, samples while disabled, a lock
  // while disabled, enable twice, unknown codes, and all-zero and all-ones
  // fields.
  task automatic queue_directed();
    queue_word(make_word(bpq_pkg::ReqSample,  32'd0,   1'b1, '0, '0));
    queue_word(make_word(bpq_pkg::ReqSample,  32'd10,  1'b0, '0, '0));
    queue_word(make_word(bpq_pkg::ReqSample,  32'd10,  1'b0, '0, '0));
    queue_word(make_word(bpq_pkg::ReqSample,  32'd11,  1'b0, '0, '0));
    queue_word(make_word(bpq_pkg::ReqSample,  32'd100, 1'b0, '1, '1));
    queue_word(make_word(bpq_pkg::ReqSample,  32'd101, 1'b1, '0, '0));
    queue_word(make_word(bpq_pkg::ReqClear,   '0,      1'b0, '0, '0));
    queue_word(make_word(bpq_pkg::ReqSample,  32'd200, 1'b0, '0, '0));
    queue_word(make_word(bpq_pkg::ReqClear,   '1,      1'b1, '1, '1));
    queue_word(make_word(bpq_pkg::ReqSample,  32'd201, 1'b1, '0, '0));
    queue_word(make_word(bpq_pkg::ReqLock,    32'hFFFF_FFF0, 1'b0, '0, 32'h20));
    queue_word(make_word(bpq_pkg::ReqSample,  32'd5,   1'b0, '0, '0));
    queue_word(make_word(bpq_pkg::ReqSample,  32'h10,  1'b0, '0, '0));
    queue_word(make_word(bpq_pkg::ReqDisable, '0,      1'b0, '0, '0));
    queue_word(make_word(bpq_pkg::ReqSample,  32'h100, 1'b0, '0, '0));
    queue_word(make_word(bpq_pkg::ReqLock,    32'h100, 1'b0, '0, '0));
    queue_word(make_word(bpq_pkg::ReqEnable,  '0,      1'b0, '0, '0));
    queue_word(make_word(bpq_pkg::ReqEnable,  '1,      1'b1, '1, '1));
    queue_word(make_word(bpq_pkg::ReqSample,  32'h101, 1'b0, '0, '0));
    queue_word(make_word(3'd5,                '1,      1'b1, '1, '1));
    queue_word(make_word(3'd6,                '0,      1'b0, '0, '0));
    queue_word(make_word(3'd7,                '1,      1'b0, '1, '1));
    queue_word(make_word(bpq_pkg::ReqSample,  '1,      1'b0, '1, '1));
    queue_word(make_word(bpq_pkg::ReqLock,    '0,      1'b0, '0, '1));
    queue_word(make_word(bpq_pkg::ReqSample,  32'hFFFF_FFFE, 1'b0, '1, '0));
  endtask

  bpq_pkg::cfg_t phase_cfg [NumPhases];

  // Stimulus and end of run.
  initial begin
    // Extremes first: reset values, all-ones threshold, maximum press time
    // and thresholds that can never be crossed, then random settings.
    phase_cfg[0] = '{1'b0, 1'b0, 32'h0000_0000, 32'd0};
    phase_cfg[1] = '{1'b0, 1'b1, 32'hFFFF_FFFF, 32'd25};
    phase_cfg[2] = '{1'b1, 1'b1, 32'h8000_0000, 32'd100};
    phase_cfg[3] = '{1'b1, 1'b0, 32'h0000_1000, 32'hFFFF_FFFF};
    phase_cfg[4] = '{1'b1, 1'b1, 32'hFFFF_FFFF, 32'd7};
    phase_cfg[5] = '{1'b1, 1'b0, 32'h0000_0000, 32'd3};
    phase_cfg[6] = '{1'b0, 1'($urandom_range(1)), $urandom(), $urandom_range(500)};
    phase_cfg[7] = '{1'b1, 1'($urandom_range(1)), $urandom(), $urandom_range(500)};

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      reg_write(bpq_pkg::RegTouchMode,  {31'b0, phase_cfg[p].touch_mode});
      reg_write(bpq_pkg::RegTouchAbove, {31'b0, phase_cfg[p].touch_above});
      reg_write(bpq_pkg::RegThreshold,  phase_cfg[p].touch_threshold);
      reg_write(bpq_pkg::RegPressMs,    phase_cfg[p].press_ms);
      // Odd phases start just short of the wrap, so their time runs through zero.
      clock_ms    = (p % 2) ? 32'hFFFF_FF00 : $urandom_range(1000);
      phase_items = 0;
      if (p == 0) queue_directed();
      phase_items = 0;
      while (phase_items < PhaseWords) begin
        case ($urandom_range(99) / 10)
          0, 1, 2, 3, 4, 5: queue_press_sequence();
          6, 7: queue_lock_sequence();
          default: queue_noise_word();
        endcase
      end
    end

    wait_drained();
    if (mismatch_count == 0 && expected_flags.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
